[rtl/assert_macros.svh]
// Assertion macros used by the top level of the validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

[rtl/ipvpt_pkg.sv]
// Package with types and constants of the IPv4 address and port text validator.
`timescale 1ns / 1ps
`default_nettype none

package ipvpt_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 17;
    localparam int COUNT_W = 3;
    localparam int INDEX_W = 3;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;

    // Character codes of interest.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

    // Field value bounds.
    localparam logic [VALUE_W-1:0] VALUE_SAT = 17'd131071;
    localparam logic [VALUE_W-1:0] OCTET_MAX = 17'd255;
    localparam logic [VALUE_W-1:0] PORT_MAX  = 17'd65535;

    // Field indexes.
    localparam logic [INDEX_W-1:0] FIELD_FIRST      = 3'd0;
    localparam logic [INDEX_W-1:0] FIELD_LAST_OCTET = 3'd3;
    localparam logic [INDEX_W-1:0] FIELD_PORT       = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

    // One character word handed to the parser, with its advance strobe.
    typedef struct packed {
        logic              fire;
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } t_char_word;

    // One result word.
    typedef struct packed {
        logic              is_valid;
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port_number;
    } t_result;

endpackage

`default_nettype wire

[rtl/ipvpt_parser.sv]
// Token parse state and its per-character update logic.
`timescale 1ns / 1ps
`default_nettype none

module ipvpt_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ipvpt_pkg::t_char_word i_word,
    output ipvpt_pkg::t_result        o_result
);
    import ipvpt_pkg::*;

    logic [INDEX_W-1:0] r_index, n_index;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_lz, n_lz;
    logic               r_err, n_err;
    logic [ADDR_W-1:0]  r_octets, n_octets;

    logic               w_is_digit;
    logic               w_sep_ok;
    logic [3:0]         w_digit;
    logic [VALUE_W+3:0] w_scaled;
    logic               w_ok;

    // Character classification; the digit value is the low nibble for '0' to '9'.
    assign w_is_digit = i_word.char_code inside {[CHAR_ZERO:CHAR_NINE]};
    assign w_sep_ok   = (i_word.char_code == CHAR_DOT && r_index < FIELD_LAST_OCTET) ||
                        (i_word.char_code == CHAR_COLON && r_index == FIELD_LAST_OCTET);
    assign w_digit    = i_word.char_code[3:0];

    // Multiply by ten as two shifts and add the new digit.
    assign w_scaled = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1) +
                      {{VALUE_W{1'b0}}, w_digit};

    // Next parse state for the character at hand.
    always_comb begin
        n_index  = r_index;
        n_value  = r_value;
        n_count  = r_count;
        n_lz     = r_lz;
        n_err    = r_err;
        n_octets = r_octets;
        if (!r_err) begin
            if (w_is_digit) begin
                if (r_count != '0 && r_lz) begin
                    n_err = 1'b1;
                end else begin
                    if (r_count == '0 && w_digit == 4'd0) begin
                        n_lz = 1'b1;
                    end
                    n_value = (w_scaled > {4'b0, VALUE_SAT}) ? VALUE_SAT
                                                            : w_scaled[VALUE_W-1:0];
                    if (r_count < COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end else if (w_sep_ok) begin
                if (r_count == '0 || r_value > OCTET_MAX) begin
                    n_err = 1'b1;
                end else begin
                    n_octets = {r_octets[ADDR_W-9:0], r_value[7:0]};
                    n_index  = r_index + 1'b1;
                    n_value  = '0;
                    n_count  = '0;
                    n_lz     = 1'b0;
                end
            end else begin
                n_err = 1'b1;
            end
        end
    end

    // Result word for a token that ends with this character.
    assign w_ok = !n_err && n_index == FIELD_PORT && n_count != '0 && n_value <= PORT_MAX;
    assign o_result.is_valid    = w_ok;
    assign o_result.address     = w_ok ? n_octets : '0;
    assign o_result.port_number = w_ok ? n_value[PORT_W-1:0] : '0;

    // State registers; the last character of a token returns them to reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_word.fire && i_word.is_last)) begin
            r_index  <= FIELD_FIRST;
            r_value  <= '0;
            r_count  <= '0;
            r_lz     <= 1'b0;
            r_err    <= 1'b0;
            r_octets <= '0;
        end else if (i_word.fire) begin
            r_index  <= n_index;
            r_value  <= n_value;
            r_count  <= n_count;
            r_lz     <= n_lz;
            r_err    <= n_err;
            r_octets <= n_octets;
        end
    end

endmodule

`default_nettype wire

[rtl/ipv4_port_text_validator.sv]
// Top level: input register, parser and result register of the validator.
// A result word goes from the input register through the parser into the result register.
// Throughput: one character word per cycle while the input is not stalled.
// A stalled result register holds the input register, which then stalls the input.
// Reset is synchronous and active low; it empties both registers and clears the parse state.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ipv4_port_text_validator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_is_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_is_valid,
    output logic [31:0]      o_address,
    output logic [15:0]      o_port_number
);
    import ipvpt_pkg::*;

    logic              r_s1_valid;
    logic [CHAR_W-1:0] r_s1_char;
    logic              r_s1_last;
    logic              r_out_valid;
    t_result           r_result;

    logic              w_out_free;
    logic              w_s1_move;
    logic              w_accept;
    t_char_word        w_word;
    t_result           w_result;

    // Pipeline flow control.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_stall    = r_s1_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_char <= i_char_code;
            r_s1_last <= i_is_last;
        end
    end

    // Parser advances on each word that leaves the input register.
    assign w_word.fire      = w_s1_move;
    assign w_word.char_code = r_s1_char;
    assign w_word.is_last   = r_s1_last;

    ipvpt_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (w_word),
        .o_result (w_result)
    );

    // Result register; only the last character of a token yields a word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_move && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_s1_move && r_s1_last) begin
            r_result <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_valid    = r_result.is_valid;
    assign o_address     = r_result.address;
    assign o_port_number = r_result.port_number;

    // An invalid token reports zero address and port.
    `ASSERT_CLK(a_invalid_zero, (o_valid && !o_is_valid) |-> (o_address == '0 && o_port_number == '0), "invalid result carries nonzero fields")
    // The input stalls only while the input register holds a word.
    `ASSERT_CLK(a_stall_only_full, o_stall |-> r_s1_valid, "input stalled with empty input register")
    // A held input word stays put.
    `ASSERT_NEXT(a_s1_hold, r_s1_valid && !w_out_free, r_s1_valid && $stable(r_s1_char) && $stable(r_s1_last), "held input word lost")
    // A taken result with nothing behind it leaves the output empty.
    `ASSERT_NEXT(a_out_drain, o_valid && !i_stall && !(w_s1_move && r_s1_last), !o_valid, "result word repeated")

endmodule

`default_nettype wire
